[hw/rtl/tfbs_pkg.sv]
// Shared constants, request and status codes, state type and cell control word
// for the transactional free block stack. No dependencies.
package tfbs_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int MAX_ALLOC   = 64;
  localparam int BLK_SPACE   = 1024;
  localparam int FMT_FIRST   = 2;
  localparam int RESET_TOTAL = 200;

  localparam int BLK_W   = 10;
  localparam int CFG_W   = 11;
  localparam int ALLOC_W = 7;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 11;
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);

  // format never goes past the block number space nor the stack depth
  localparam int FMT_CAP = (BLK_SPACE < MAX_BLOCKS + FMT_FIRST) ?
                           BLK_SPACE : MAX_BLOCKS + FMT_FIRST;

  localparam logic [REQ_W-1:0] REQ_ALLOC    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BEGIN    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_COMMIT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ROLLBACK = 3'd4;
  localparam logic [REQ_W-1:0] REQ_FORMAT   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FMT
  } tfbs_state_t;

  // one control word broadcast to every cell of the chain
  typedef struct packed {
    logic com_push;
    logic com_pop;
    logic wrk_push;
    logic wrk_pop;
    logic ld_wrk;   // working <= committed
    logic ld_com;   // committed <= working
  } tfbs_cell_op_t;

endpackage

[hw/rtl/tfbs_cell.sv]
// One stack cell: a committed entry and a working entry, each shifting toward
// or away from the top. Depends on tfbs_pkg.
module tfbs_cell (
  input  logic                        clk,
  input  tfbs_pkg::tfbs_cell_op_t     op,
  input  logic [tfbs_pkg::BLK_W-1:0]  com_above,
  input  logic [tfbs_pkg::BLK_W-1:0]  com_below,
  input  logic [tfbs_pkg::BLK_W-1:0]  wrk_above,
  input  logic [tfbs_pkg::BLK_W-1:0]  wrk_below,
  output logic [tfbs_pkg::BLK_W-1:0]  com,
  output logic [tfbs_pkg::BLK_W-1:0]  wrk
);

  always_ff @(posedge clk) begin
    if (op.ld_com) begin
      com <= wrk;
    end else if (op.com_push) begin
      com <= com_above;
    end else if (op.com_pop) begin
      com <= com_below;
    end
  end

  always_ff @(posedge clk) begin
    if (op.ld_wrk) begin
      wrk <= com;
    end else if (op.wrk_push) begin
      wrk <= wrk_above;
    end else if (op.wrk_pop) begin
      wrk <= wrk_below;
    end
  end

endmodule

[hw/rtl/tfbs_chain.sv]
// Row of stack cells; cell 0 holds the top of both copies.
// Depends on tfbs_pkg and tfbs_cell.
module tfbs_chain (
  input  logic                        clk,
  input  tfbs_pkg::tfbs_cell_op_t     op,
  input  logic [tfbs_pkg::BLK_W-1:0]  push_val,
  output logic [tfbs_pkg::BLK_W-1:0]  com_head,
  output logic [tfbs_pkg::BLK_W-1:0]  wrk_head
);

  logic [tfbs_pkg::BLK_W-1:0] com_q [tfbs_pkg::MAX_BLOCKS];
  logic [tfbs_pkg::BLK_W-1:0] wrk_q [tfbs_pkg::MAX_BLOCKS];

  for (genvar j = 0; j < tfbs_pkg::MAX_BLOCKS; j++) begin : g_cell
    logic [tfbs_pkg::BLK_W-1:0] com_above, com_below, wrk_above, wrk_below;

    if (j == 0) begin : g_head
      assign com_above = push_val;
      assign wrk_above = push_val;
    end else begin : g_mid
      assign com_above = com_q[j-1];
      assign wrk_above = wrk_q[j-1];
    end

    if (j == tfbs_pkg::MAX_BLOCKS - 1) begin : g_tail
      assign com_below = '0;
      assign wrk_below = '0;
    end else begin : g_body
      assign com_below = com_q[j+1];
      assign wrk_below = wrk_q[j+1];
    end

    tfbs_cell u_cell (
      .clk       (clk),
      .op        (op),
      .com_above (com_above),
      .com_below (com_below),
      .wrk_above (wrk_above),
      .wrk_below (wrk_below),
      .com       (com_q[j]),
      .wrk       (wrk_q[j])
    );
  end

  assign com_head = com_q[0];
  assign wrk_head = wrk_q[0];

endmodule

[hw/rtl/tfbs_ctrl.sv]
// Request sequencer: stack depth counters, transaction flag, pop and format
// sweeps, and the result register. Depends on tfbs_pkg.
module tfbs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tfbs_pkg::CFG_W-1:0]    num_blocks,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tfbs_pkg::REQ_W-1:0]    req_type,
  input  logic [tfbs_pkg::ALLOC_W-1:0]  alloc_count,
  input  logic [tfbs_pkg::BLK_W-1:0]    free_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tfbs_pkg::BLK_W-1:0]    block_number,
  output logic                          got_block,
  output logic [tfbs_pkg::STAT_W-1:0]   status,
  output logic                          txn_open,
  output logic [tfbs_pkg::OCNT_W-1:0]   free_count,
  output logic                          last,
  output tfbs_pkg::tfbs_cell_op_t       op,
  output logic [tfbs_pkg::BLK_W-1:0]    push_val,
  input  logic [tfbs_pkg::BLK_W-1:0]    com_head,
  input  logic [tfbs_pkg::BLK_W-1:0]    wrk_head
);

  localparam int CNT_W   = tfbs_pkg::CNT_W;
  localparam int CFG_W   = tfbs_pkg::CFG_W;
  localparam int ALLOC_W = tfbs_pkg::ALLOC_W;

  tfbs_pkg::tfbs_state_t state, state_next;

  logic                              txn;
  logic [CNT_W-1:0]                  com_top, wrk_top, fin_top;
  logic [ALLOC_W-1:0]                rem;
  logic [tfbs_pkg::STAT_W-1:0]       st_hold;
  logic [CFG_W-1:0]                  fmt_val, fmt_lim;

  logic [CNT_W-1:0]   act_top;
  logic [ALLOC_W-1:0] want, take;
  logic               short_list;
  logic [CFG_W-1:0]   lim;
  logic [CNT_W-1:0]   fmt_cnt;
  logic               acc, out_free, fmt_more;
  logic               out_valid_next;

  assign act_top    = txn ? wrk_top : com_top;
  assign want       = (alloc_count > ALLOC_W'(tfbs_pkg::MAX_ALLOC)) ?
                      ALLOC_W'(tfbs_pkg::MAX_ALLOC) : alloc_count;
  assign short_list = act_top < CNT_W'(want);
  assign take       = short_list ? ALLOC_W'(act_top) : want;
  assign lim        = (num_blocks > CFG_W'(tfbs_pkg::FMT_CAP)) ?
                      CFG_W'(tfbs_pkg::FMT_CAP) : num_blocks;
  assign fmt_cnt    = (lim > CFG_W'(tfbs_pkg::FMT_FIRST)) ?
                      CNT_W'(lim - CFG_W'(tfbs_pkg::FMT_FIRST)) : '0;
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == tfbs_pkg::ST_IDLE) && out_free;
  assign acc        = in_valid && in_ready;
  assign fmt_more   = fmt_val < fmt_lim;

  always_comb begin
    state_next = state;
    unique case (state)
      tfbs_pkg::ST_IDLE: begin
        if (acc) begin
          if (req_type == tfbs_pkg::REQ_ALLOC && take != '0) begin
            state_next = tfbs_pkg::ST_POP;
          end else if (req_type == tfbs_pkg::REQ_FORMAT) begin
            state_next = tfbs_pkg::ST_FMT;
          end
        end
      end
      tfbs_pkg::ST_POP: begin
        if (out_free && rem == ALLOC_W'(1)) state_next = tfbs_pkg::ST_IDLE;
      end
      tfbs_pkg::ST_FMT: begin
        if (!fmt_more) state_next = tfbs_pkg::ST_IDLE;
      end
      default: state_next = tfbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op       = '0;
    push_val = free_block;
    unique case (state)
      tfbs_pkg::ST_IDLE: begin
        if (acc) begin
          if (req_type == tfbs_pkg::REQ_FREE &&
              act_top < CNT_W'(tfbs_pkg::MAX_BLOCKS)) begin
            op.com_push = !txn;
            op.wrk_push = txn;
          end
          if (req_type == tfbs_pkg::REQ_BEGIN && !txn) op.ld_wrk = 1'b1;
          if (req_type == tfbs_pkg::REQ_COMMIT && txn) op.ld_com = 1'b1;
        end
      end
      tfbs_pkg::ST_POP: begin
        if (out_free) begin
          op.com_pop = !txn;
          op.wrk_pop = txn;
        end
      end
      tfbs_pkg::ST_FMT: begin
        push_val    = tfbs_pkg::BLK_W'(fmt_val);
        op.com_push = fmt_more;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (acc) begin
      // an alloc that takes blocks sends its beats from the pop sweep
      out_valid_next = !(req_type == tfbs_pkg::REQ_ALLOC && take != '0);
    end else if (state == tfbs_pkg::ST_POP && out_free) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tfbs_pkg::ST_FMT;
      txn       <= 1'b0;
      com_top   <= '0;
      wrk_top   <= '0;
      rem       <= '0;
      fmt_val   <= CFG_W'(tfbs_pkg::FMT_FIRST);
      fmt_lim   <= (tfbs_pkg::RESET_TOTAL > tfbs_pkg::FMT_CAP) ?
                   CFG_W'(tfbs_pkg::FMT_CAP) : CFG_W'(tfbs_pkg::RESET_TOTAL);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;

      unique case (state)
        tfbs_pkg::ST_IDLE: begin
          if (acc) begin
            block_number <= '0;
            got_block    <= 1'b0;
            last         <= 1'b1;
            unique case (req_type)
              tfbs_pkg::REQ_ALLOC: begin
                status     <= short_list ? tfbs_pkg::STAT_EMPTY : tfbs_pkg::STAT_OK;
                txn_open   <= txn;
                free_count <= tfbs_pkg::OCNT_W'(act_top);
                if (take != '0) begin
                  rem     <= take;
                  fin_top <= act_top - CNT_W'(take);
                  st_hold <= short_list ? tfbs_pkg::STAT_EMPTY : tfbs_pkg::STAT_OK;
                end
              end
              tfbs_pkg::REQ_FREE: begin
                txn_open <= txn;
                if (act_top >= CNT_W'(tfbs_pkg::MAX_BLOCKS)) begin
                  status     <= tfbs_pkg::STAT_FULL;
                  free_count <= tfbs_pkg::OCNT_W'(act_top);
                end else begin
                  status     <= tfbs_pkg::STAT_OK;
                  free_count <= tfbs_pkg::OCNT_W'(act_top + CNT_W'(1));
                  if (txn) wrk_top <= act_top + CNT_W'(1);
                  else     com_top <= act_top + CNT_W'(1);
                end
              end
              tfbs_pkg::REQ_BEGIN: begin
                txn_open   <= 1'b1;
                free_count <= tfbs_pkg::OCNT_W'(act_top);
                if (txn) begin
                  status <= tfbs_pkg::STAT_IGNORED;
                end else begin
                  status  <= tfbs_pkg::STAT_OK;
                  wrk_top <= com_top;
                  txn     <= 1'b1;
                end
              end
              tfbs_pkg::REQ_COMMIT: begin
                txn_open   <= 1'b0;
                free_count <= tfbs_pkg::OCNT_W'(act_top);
                if (!txn) begin
                  status <= tfbs_pkg::STAT_IGNORED;
                end else begin
                  status  <= tfbs_pkg::STAT_OK;
                  com_top <= wrk_top;
                  wrk_top <= '0;
                  txn     <= 1'b0;
                end
              end
              tfbs_pkg::REQ_ROLLBACK: begin
                txn_open   <= 1'b0;
                free_count <= tfbs_pkg::OCNT_W'(com_top);
                if (!txn) begin
                  status <= tfbs_pkg::STAT_IGNORED;
                end else begin
                  status  <= tfbs_pkg::STAT_OK;
                  wrk_top <= '0;
                  txn     <= 1'b0;
                end
              end
              tfbs_pkg::REQ_FORMAT: begin
                // result goes out now; the committed copy refills in ST_FMT
                status     <= tfbs_pkg::STAT_OK;
                txn_open   <= txn;
                free_count <= tfbs_pkg::OCNT_W'(txn ? wrk_top : fmt_cnt);
                com_top    <= '0;
                fmt_val    <= CFG_W'(tfbs_pkg::FMT_FIRST);
                fmt_lim    <= lim;
              end
              default: begin
                status     <= tfbs_pkg::STAT_IGNORED;
                txn_open   <= txn;
                free_count <= tfbs_pkg::OCNT_W'(act_top);
              end
            endcase
          end
        end
        tfbs_pkg::ST_POP: begin
          if (out_free) begin
            block_number <= txn ? wrk_head : com_head;
            got_block    <= 1'b1;
            status       <= st_hold;
            txn_open     <= txn;
            free_count   <= tfbs_pkg::OCNT_W'(fin_top);
            last         <= (rem == ALLOC_W'(1));
            rem          <= rem - ALLOC_W'(1);
            if (txn) wrk_top <= wrk_top - CNT_W'(1);
            else     com_top <= com_top - CNT_W'(1);
          end
        end
        tfbs_pkg::ST_FMT: begin
          if (fmt_more) begin
            com_top <= com_top + CNT_W'(1);
            fmt_val <= fmt_val + CFG_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/transactional_free_block_stack_core.sv]
// Top level of the transactional free block stack: configuration register,
// stream ports, sequencer and cell chain. Depends on tfbs_pkg, tfbs_ctrl, tfbs_chain.
// Results: a single-result request shows its beat in the cycle after acceptance; an
//   alloc of k blocks sends its beats from the pop state, one beat a cycle while the
//   result stream does not stall, set by the chain shifting one entry per pop.
// Throughput: input is taken only while idle and the result register is free; an
//   alloc holds input until its last beat is registered, and a format holds input
//   while the chain takes one push a cycle.
// Reset: control clears at once, then a format sweep fills blocks 2..199 before the
//   first request is taken; configuration writes are taken throughout.
module transactional_free_block_stack_core (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // alloc_count[6:0], free_block[16:7], zero pad
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // block_number[9:0], status[11:10], txn_open[12],
                                 // free_count[23:13]
  output logic        m_tuser,   // got_block
  output logic        m_tlast
);

  localparam int CFG_W = tfbs_pkg::CFG_W;

  logic [CFG_W-1:0] num_blocks;
  logic             reg_sel;

  tfbs_pkg::tfbs_cell_op_t          op;
  logic [tfbs_pkg::BLK_W-1:0]       push_val, com_head, wrk_head;
  logic [tfbs_pkg::BLK_W-1:0]       block_number;
  logic [tfbs_pkg::STAT_W-1:0]      status;
  logic                             txn_open;
  logic [tfbs_pkg::OCNT_W-1:0]      free_count;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? 32'(num_blocks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_blocks <= CFG_W'(tfbs_pkg::RESET_TOTAL);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      num_blocks <= pwdata[CFG_W-1:0];
    end
  end

  tfbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .num_blocks   (num_blocks),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .req_type     (s_tuser),
    .alloc_count  (s_tdata[6:0]),
    .free_block   (s_tdata[16:7]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .block_number (block_number),
    .got_block    (m_tuser),
    .status       (status),
    .txn_open     (txn_open),
    .free_count   (free_count),
    .last         (m_tlast),
    .op           (op),
    .push_val     (push_val),
    .com_head     (com_head),
    .wrk_head     (wrk_head)
  );

  tfbs_chain u_chain (
    .clk      (clk),
    .op       (op),
    .push_val (push_val),
    .com_head (com_head),
    .wrk_head (wrk_head)
  );

  assign m_tdata = {free_count, txn_open, status, block_number};

endmodule

[tb/testbench.sv]
// Self-checking bench for transactional_free_block_stack_core: scoreboard class with its own
// free-list model, stream drivers with random stalls, APB register writes. Needs tfbs_pkg.
`timescale 1ns / 100ps

typedef struct packed {
  logic [tfbs_pkg::BLK_W-1:0]  blk;
  logic                        got;
  logic [tfbs_pkg::STAT_W-1:0] st;
  logic                        txn;
  logic [tfbs_pkg::OCNT_W-1:0] cnt;
  logic                        lst;
} alloc_beat_t;

class free_list_scoreboard;
  logic [tfbs_pkg::BLK_W-1:0] com_list [tfbs_pkg::MAX_BLOCKS];
  logic [tfbs_pkg::BLK_W-1:0] wrk_list [tfbs_pkg::MAX_BLOCKS];
  int unsigned      com_top;
  int unsigned      wrk_top;
  int unsigned      total;
  bit               txn;
  alloc_beat_t      due_beats[$];
  int               errors;

  function new();
    foreach (com_list[i]) begin
      com_list[i] = '0;
      wrk_list[i] = '0;
    end
    wrk_top = 0;
    txn     = 0;
    errors  = 0;
    total   = tfbs_pkg::RESET_TOTAL;
    format_list();
  endfunction

  function void set_total(logic [tfbs_pkg::CFG_W-1:0] value);
    total = value;
  endfunction

  function int unsigned active_top();
    return txn ? wrk_top : com_top;
  endfunction

  // rebuild committed copy ascending from the first free block
  function void format_list();
    int unsigned lim;
    lim = (total > tfbs_pkg::BLK_SPACE) ? tfbs_pkg::BLK_SPACE : total;
    if (lim > tfbs_pkg::MAX_BLOCKS + tfbs_pkg::FMT_FIRST) begin
      lim = tfbs_pkg::MAX_BLOCKS + tfbs_pkg::FMT_FIRST;
    end
    com_top = 0;
    for (int unsigned i = tfbs_pkg::FMT_FIRST; i < lim; i++) begin
      com_list[com_top] = tfbs_pkg::BLK_W'(i);
      com_top++;
    end
  endfunction

  function void add_beat(logic [tfbs_pkg::BLK_W-1:0] blk, logic got,
                         logic [tfbs_pkg::STAT_W-1:0] st, logic lst);
    alloc_beat_t b;
    b.blk = blk;
    b.got = got;
    b.st  = st;
    b.txn = txn;
    b.cnt = tfbs_pkg::OCNT_W'(active_top());
    b.lst = lst;
    due_beats = {due_beats, b};
  endfunction

  function void note_request(logic [tfbs_pkg::REQ_W-1:0] req,
                             logic [tfbs_pkg::ALLOC_W-1:0] want_in,
                             logic [tfbs_pkg::BLK_W-1:0] fblk);
    int unsigned                 want;
    logic [tfbs_pkg::BLK_W-1:0]  popped[$];
    logic [tfbs_pkg::STAT_W-1:0] st;
    st = tfbs_pkg::STAT_OK;
    case (req)
      tfbs_pkg::REQ_ALLOC: begin
        want = (want_in > tfbs_pkg::MAX_ALLOC) ? tfbs_pkg::MAX_ALLOC : want_in;
        while (popped.size() < want && active_top() > 0) begin
          if (txn) begin
            wrk_top--;
            popped = {popped, wrk_list[wrk_top]};
          end else begin
            com_top--;
            popped = {popped, com_list[com_top]};
          end
        end
        if (popped.size() < want) st = tfbs_pkg::STAT_EMPTY;
        if (popped.size() == 0) begin
          add_beat('0, 1'b0, st, 1'b1);
        end else begin
          foreach (popped[i]) add_beat(popped[i], 1'b1, st, i == popped.size() - 1);
        end
        return;
      end
      tfbs_pkg::REQ_FREE: begin
        if (active_top() >= tfbs_pkg::MAX_BLOCKS) begin
          st = tfbs_pkg::STAT_FULL;
        end else if (txn) begin
          wrk_list[wrk_top] = fblk;
          wrk_top++;
        end else begin
          com_list[com_top] = fblk;
          com_top++;
        end
      end
      tfbs_pkg::REQ_BEGIN: begin
        if (txn) begin
          st = tfbs_pkg::STAT_IGNORED;
        end else begin
          wrk_list = com_list;
          wrk_top  = com_top;
          txn      = 1;
        end
      end
      tfbs_pkg::REQ_COMMIT: begin
        if (!txn) begin
          st = tfbs_pkg::STAT_IGNORED;
        end else begin
          com_list = wrk_list;
          com_top  = wrk_top;
          wrk_top  = 0;
          txn      = 0;
        end
      end
      tfbs_pkg::REQ_ROLLBACK: begin
        if (!txn) begin
          st = tfbs_pkg::STAT_IGNORED;
        end else begin
          wrk_top = 0;
          txn     = 0;
        end
      end
      tfbs_pkg::REQ_FORMAT: format_list();
      default: st = tfbs_pkg::STAT_IGNORED;
    endcase
    add_beat('0, 1'b0, st, 1'b1);
  endfunction

  function void compare_field(string name, logic [31:0] act, int unsigned exp);
    if (act !== 32'(exp)) begin
      $error("%s: expected %0d, actual %0d", name, exp, act);
      errors++;
    end
  endfunction

  function void check_beat(logic [23:0] data, logic user, logic lst);
    alloc_beat_t want;
    if (due_beats.size() == 0) begin
      $error("result beat with nothing pending: tdata %h", data);
      errors++;
      return;
    end
    want = due_beats.pop_front();
    compare_field("block_number", 32'(data[9:0]),   want.blk);
    compare_field("status",       32'(data[11:10]), want.st);
    compare_field("txn_open",     32'(data[12]),    want.txn);
    compare_field("free_count",   32'(data[23:13]), want.cnt);
    compare_field("got_block",    32'(user),        want.got);
    compare_field("last",         32'(lst),         want.lst);
  endfunction
endclass

module testbench;

  localparam logic [2:0]                 ADDR_TOTAL   = 3'd0;
  localparam logic [tfbs_pkg::REQ_W-1:0] REQ_UNUSED_A = 3'd6;
  localparam logic [tfbs_pkg::REQ_W-1:0] REQ_UNUSED_B = 3'd7;
  localparam int             RANDOM_ITEMS  = 260;
  localparam int             PHASES        = 5;
  localparam int             CALM_AFTER    = 270;
  localparam int             SETTLE_CYCLES = 2100;
  localparam longint         TIMEOUT_NS    = 64'd60_000_000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  free_list_scoreboard sb;
  bit                  calm;
  int                  sent_count;

  transactional_free_block_stack_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // alloc_count[6:0], free_block[16:7], zero pad
    .s_tuser  (s_tuser),   // req_type[2:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // block_number[9:0], status[11:10], txn_open[12], free_count[23:13]
    .m_tuser  (m_tuser),   // got_block
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
  end

  // result side back-pressure in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready   <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [tfbs_pkg::ALLOC_W-1:0] rand_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return tfbs_pkg::ALLOC_W'($urandom_range(0, 12));
    if (r < 19) return tfbs_pkg::ALLOC_W'($urandom_range(0, tfbs_pkg::MAX_ALLOC));
    return tfbs_pkg::ALLOC_W'($urandom_range(tfbs_pkg::MAX_ALLOC + 1, 127));
  endfunction

  function automatic logic [tfbs_pkg::BLK_W-1:0] rand_blk();
    return tfbs_pkg::BLK_W'($urandom_range(0, 1023));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_req(input logic [tfbs_pkg::REQ_W-1:0] req,
                          input logic [tfbs_pkg::ALLOC_W-1:0] cnt,
                          input logic [tfbs_pkg::BLK_W-1:0] blk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {7'b0, blk, cnt};
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, cnt, blk);
    sent_count++;
    if (sent_count >= CALM_AFTER) calm = 1'b1;
    @(negedge clk);
  endtask

  // drain results and let any fill sweep finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.due_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_total(input logic [tfbs_pkg::CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TOTAL;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_total(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    // read back
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[tfbs_pkg::CFG_W-1:0] !== value) begin
      $error("num_blocks: expected %0d, actual %0d", value, prdata[tfbs_pkg::CFG_W-1:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly begin / alloc-free mix / commit-or-rollback, the rest single noise requests
  task automatic random_items(input int unsigned n);
    int unsigned sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        send_req(tfbs_pkg::REQ_BEGIN, rand_count(), rand_blk());
        sent++;
        repeat ($urandom_range(1, 6)) begin
          send_req($urandom_range(0, 1) ? tfbs_pkg::REQ_ALLOC : tfbs_pkg::REQ_FREE,
                   rand_count(), rand_blk());
          sent++;
        end
        send_req(($urandom_range(0, 2) != 0) ? tfbs_pkg::REQ_COMMIT : tfbs_pkg::REQ_ROLLBACK,
                 rand_count(), rand_blk());
        sent++;
      end else begin
        send_req(tfbs_pkg::REQ_W'($urandom_range(0, 7)), rand_count(), rand_blk());
        sent++;
      end
    end
  endtask

  initial begin
    sb         = new();
    calm       = 1'b0;
    sent_count = 0;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset list of 198 blocks, 2..199
    send_req(tfbs_pkg::REQ_ALLOC,    7'd0,   10'd0);
    send_req(tfbs_pkg::REQ_ALLOC,    7'd1,   10'd0);
    send_req(tfbs_pkg::REQ_ALLOC,    7'd64,  10'd1023);
    send_req(tfbs_pkg::REQ_ALLOC,    7'd127, 10'd0);
    send_req(tfbs_pkg::REQ_FREE,     7'd127, 10'd0);
    send_req(tfbs_pkg::REQ_FREE,     7'd0,   10'd1023);
    send_req(tfbs_pkg::REQ_FREE,     7'd0,   10'd1);
    send_req(tfbs_pkg::REQ_FREE,     7'd0,   10'd1023);
    send_req(tfbs_pkg::REQ_COMMIT,   7'd0,   10'd0);
    send_req(tfbs_pkg::REQ_ROLLBACK, 7'd0,   10'd0);
    send_req(tfbs_pkg::REQ_BEGIN,    7'd0,   10'd0);
    send_req(tfbs_pkg::REQ_BEGIN,    7'd0,   10'd0);
    send_req(tfbs_pkg::REQ_ALLOC,    7'd3,   10'd0);
    send_req(tfbs_pkg::REQ_FREE,     7'd0,   10'd5);
    send_req(tfbs_pkg::REQ_FORMAT,   7'd0,   10'd0);
    send_req(tfbs_pkg::REQ_COMMIT,   7'd0,   10'd0);
    send_req(REQ_UNUSED_A,           7'd0,   10'd0);
    send_req(REQ_UNUSED_B,           7'd127, 10'd1023);

    // one block only: short alloc, then nothing left
    settle();
    write_total(11'd3);
    send_req(tfbs_pkg::REQ_FORMAT, 7'd0, 10'd0);
    send_req(tfbs_pkg::REQ_ALLOC,  7'd2, 10'd0);
    send_req(tfbs_pkg::REQ_ALLOC,  7'd1, 10'd0);

    // total below the first free block
    settle();
    write_total(11'd0);
    send_req(tfbs_pkg::REQ_FORMAT, 7'd0, 10'd0);
    send_req(tfbs_pkg::REQ_ALLOC,  7'd1, 10'd0);

    // oversize total caps at the block space; top up to a full list
    settle();
    write_total(11'd2047);
    send_req(tfbs_pkg::REQ_FORMAT,   7'd0, 10'd0);
    send_req(tfbs_pkg::REQ_FREE,     7'd0, 10'd0);
    send_req(tfbs_pkg::REQ_FREE,     7'd0, 10'd1);
    send_req(tfbs_pkg::REQ_FREE,     7'd0, 10'd2);
    send_req(tfbs_pkg::REQ_BEGIN,    7'd0, 10'd0);
    send_req(tfbs_pkg::REQ_ROLLBACK, 7'd0, 10'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       write_total(11'd3);
        1:       write_total(11'd1024);
        4:       write_total(tfbs_pkg::CFG_W'($urandom_range(3, 1024)));
        default: write_total(tfbs_pkg::CFG_W'($urandom_range(4, 64)));
      endcase
      send_req(tfbs_pkg::REQ_FORMAT, rand_count(), rand_blk());
      random_items(RANDOM_ITEMS / PHASES);
    end

    s_tvalid <= 1'b0;
    while (sb.due_beats.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
